/* design/assert_macros.svh */
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cond is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* design/cffp_pkg.sv */
// Constants and types for the command frame field parser.
`timescale 1ns / 1ps
package cffp_pkg;

  localparam int unsigned FRAME_LEN  = 16;
  localparam int unsigned HEADER_LEN = 3;

  localparam int unsigned POS_W = $clog2(FRAME_LEN + 1);

  localparam logic [POS_W-1:0] CMD_POS   = POS_W'(2);
  localparam logic [POS_W-1:0] WIN_START = POS_W'(HEADER_LEN);
  localparam logic [POS_W-1:0] WIN_END   = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] FRAME_END = POS_W'(FRAME_LEN);

  localparam logic [7:0] SEP_CHAR   = 8'h3B;
  localparam logic [7:0] TERM_CHAR  = 8'h00;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  localparam logic [7:0] CMD_RESET = 8'h6C;  // 'l'
  localparam logic [3:0] STATE_SLOT_RESET = 4'd1;
  localparam logic [3:0] RATE_SLOT_RESET  = 4'd2;

  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] MAG_CAP = 17'd32768;
  localparam logic [ACC_W-1:0] POS_MAX = 17'd32767;
  localparam logic [5:0] SEP_MAX = 6'd63;

  typedef enum logic [1:0] {
    CFG_COMMAND_CODE = 2'd0,
    CFG_STATE_SLOT   = 2'd1,
    CFG_RATE_SLOT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

endpackage

/* design/command_frame_field_parser_core.sv */
// Top level of the command frame field parser: frame scan, slot parse and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one received byte per transaction and emits one result transaction for every zero
// (terminator) byte; other bytes produce no result. Each byte is handled by the scan logic
// that sits between the frame state registers and the result register, so a
// byte can be accepted in every cycle. A pending result waits in the output register; the
// input side keeps accepting while that register is empty or being drained in the same cycle.
// Configuration writes are taken at any edge with cfg_we_i high and should happen while idle.
module command_frame_field_parser_core
  import cffp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] command_matched, [16:1] state_value, [32:17] rate_value, [33] frame_overflow,
  // [39:34] zero
  output logic [39:0] m_axis_tdata
);

  logic [7:0]       cmd_code_q;
  logic [3:0]       state_slot_q, rate_slot_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [5:0]       sep_cnt_q, sep_cnt_d;
  phase_e           phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [15:0]      pend_state_q, pend_state_d;
  logic [15:0]      pend_rate_q, pend_rate_d;
  logic [15:0]      held_state_q, held_state_d;
  logic [15:0]      held_rate_q, held_rate_d;
  logic             ovf_q, ovf_d;

  logic             out_valid_q, out_valid_d;
  logic             out_match_q, out_ovf_q;
  logic [15:0]      out_state_q, out_rate_q;

  logic             in_fire, term_fire, in_win, is_sep, is_space, match;
  logic [7:0]       rx_byte, cmd_eff;
  logic [ACC_W-1:0] mag_cap;
  logic [15:0]      slot_val;
  logic [19:0]      acc_next;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign term_fire     = in_fire && (rx_byte == TERM_CHAR);

  assign in_win   = (pos_q >= WIN_START) && (pos_q <= WIN_END);
  assign is_sep   = (rx_byte == SEP_CHAR) || (rx_byte == TERM_CHAR);
  assign is_space = (rx_byte == SPACE_CHAR) || ((rx_byte >= TAB_CHAR) && (rx_byte <= CR_CHAR));

  // Value of the slot being closed, clamped to the 16-bit signed range.
  always_comb begin
    if (neg_q) begin
      mag_cap  = (acc_q > MAG_CAP) ? MAG_CAP : acc_q;
      slot_val = 16'(17'h10000 - mag_cap);
    end else begin
      mag_cap  = (acc_q > POS_MAX) ? POS_MAX : acc_q;
      slot_val = mag_cap[15:0];
    end
  end

  assign acc_next = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 20'(rx_byte - ZERO_CHAR);

  assign cmd_eff = (pos_q == CMD_POS) ? TERM_CHAR : cmd_q;
  assign match   = (cmd_eff == cmd_code_q);

  always_comb begin
    pos_d        = pos_q;
    cmd_d        = cmd_q;
    sep_cnt_d    = sep_cnt_q;
    phase_d      = phase_q;
    neg_d        = neg_q;
    acc_d        = acc_q;
    pend_state_d = pend_state_q;
    pend_rate_d  = pend_rate_q;
    held_state_d = held_state_q;
    held_rate_d  = held_rate_q;
    ovf_d        = ovf_q;

    if (in_fire) begin
      if (rx_byte != TERM_CHAR && pos_q >= FRAME_END) begin
        // drop bytes past the frame length
        ovf_d = 1'b1;
      end else begin
        if (pos_q == CMD_POS) cmd_d = rx_byte;
        if (in_win) begin
          if (is_sep) begin
            if (sep_cnt_q != 6'd0) begin
              if (sep_cnt_q == {2'b00, state_slot_q}) pend_state_d = slot_val;
              if (sep_cnt_q == {2'b00, rate_slot_q}) pend_rate_d = slot_val;
            end
            if (sep_cnt_q < SEP_MAX) sep_cnt_d = sep_cnt_q + 6'd1;
            phase_d = PH_SKIP;
            neg_d   = 1'b0;
            acc_d   = '0;
          end else if (sep_cnt_q != 6'd0) begin
            if (phase_q == PH_SKIP && (rx_byte == MINUS_CHAR || rx_byte == PLUS_CHAR)) begin
              neg_d   = (rx_byte == MINUS_CHAR);
              phase_d = PH_DIGITS;
            end else if (!(phase_q == PH_SKIP && is_space) && phase_q != PH_DONE) begin
              if (rx_byte >= ZERO_CHAR && rx_byte <= NINE_CHAR) begin
                phase_d = PH_DIGITS;
                acc_d   = (acc_next > 20'(MAG_CAP)) ? MAG_CAP : acc_next[ACC_W-1:0];
              end else begin
                phase_d = PH_DONE;
              end
            end
          end
        end
        pos_d = pos_q + POS_W'(1);
      end

      if (rx_byte == TERM_CHAR) begin
        if (match) begin
          held_state_d = pend_state_d;
          held_rate_d  = pend_rate_d;
        end
        // start a new frame
        pos_d        = '0;
        cmd_d        = '0;
        sep_cnt_d    = '0;
        phase_d      = PH_SKIP;
        neg_d        = 1'b0;
        acc_d        = '0;
        pend_state_d = '0;
        pend_rate_d  = '0;
        ovf_d        = 1'b0;
      end
    end
  end

  always_comb begin
    if (term_fire) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_code_q   <= CMD_RESET;
      state_slot_q <= STATE_SLOT_RESET;
      rate_slot_q  <= RATE_SLOT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COMMAND_CODE: cmd_code_q   <= cfg_wdata_i;
        CFG_STATE_SLOT:   state_slot_q <= cfg_wdata_i[3:0];
        CFG_RATE_SLOT:    rate_slot_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      cmd_q        <= '0;
      sep_cnt_q    <= '0;
      phase_q      <= PH_SKIP;
      neg_q        <= 1'b0;
      acc_q        <= '0;
      pend_state_q <= '0;
      pend_rate_q  <= '0;
      held_state_q <= '0;
      held_rate_q  <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      cmd_q        <= cmd_d;
      sep_cnt_q    <= sep_cnt_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      acc_q        <= acc_d;
      pend_state_q <= pend_state_d;
      pend_rate_q  <= pend_rate_d;
      held_state_q <= held_state_d;
      held_rate_q  <= held_rate_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Capture the report of each terminator.
  always_ff @(posedge clk_i) begin
    if (term_fire) begin
      out_match_q <= match;
      out_state_q <= held_state_d;
      out_rate_q  <= held_rate_d;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_rate_q, out_state_q, out_match_q};

  `ASSERT_NEVER(a_pos_range, pos_q > FRAME_END, "byte position ran past frame length")
  `ASSERT_CLK(a_term_result, term_fire |=> (out_valid_q && pos_q == '0), "terminator lost")
  `ASSERT_CLK(a_sep_in_window, (sep_cnt_q != 6'd0) |-> (pos_q > WIN_START),
              "separator counted outside scan window")
  `ASSERT_CLK(a_acc_cap, acc_q <= MAG_CAP, "accumulator above saturation cap")

endmodule

/* bench/tb_command_frame_field_parser_core.sv */
// Self-checking bench for command_frame_field_parser_core: byte stream in, frame results out.
`timescale 1ns / 1ps
module tb_command_frame_field_parser_core;
  import cffp_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES    = 317;

  // Same bit order as m_axis_tdata[33:0]
  typedef struct packed {
    logic        frame_overflow;
    logic [15:0] rate_value;
    logic [15:0] state_value;
    logic        command_matched;
  } frame_report_t;

  // Shadow copy of the parser: tracks the frame byte by byte and queues the report
  // that each terminator should produce.
  class frame_parser_shadow;
    bit [7:0]  cmd_code;
    bit [3:0]  state_sel;
    bit [3:0]  rate_sel;
    bit [6:0]  pos;
    bit [7:0]  frame_cmd;
    bit [5:0]  sep_cnt;
    phase_e    scan_phase;
    bit        neg;
    bit [16:0] acc;
    bit [15:0] pend_state;
    bit [15:0] pend_rate;
    bit [15:0] held_state;
    bit [15:0] held_rate;
    bit        ovf;
    frame_report_t awaited[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned matches_seen;
    int unsigned overflows_seen;

    function new();
      cmd_code   = CMD_RESET;
      state_sel  = STATE_SLOT_RESET;
      rate_sel   = RATE_SLOT_RESET;
      held_state = '0;
      held_rate  = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = '0;
      frame_cmd  = '0;
      sep_cnt    = '0;
      scan_phase = PH_SKIP;
      neg        = 1'b0;
      acc        = '0;
      pend_state = '0;
      pend_rate  = '0;
      ovf        = 1'b0;
    endfunction

    function void set_register(cfg_idx_e idx, bit [7:0] val);
      case (idx)
        CFG_COMMAND_CODE: cmd_code  = val;
        CFG_STATE_SLOT:   state_sel = val[3:0];
        CFG_RATE_SLOT:    rate_sel  = val[3:0];
        default: ;
      endcase
    endfunction

    // Clamp the magnitude to the signed 16-bit range.
    function bit [15:0] slot_value();
      bit [16:0] mag;
      mag = acc;
      if (neg) begin
        if (mag > MAG_CAP) mag = MAG_CAP;
        return 16'(17'h10000 - mag);
      end
      if (mag > POS_MAX) mag = POS_MAX;
      return mag[15:0];
    endfunction

    function void scan(bit [7:0] c);
      bit [15:0]   v;
      int unsigned a;
      if (c == SEP_CHAR || c == TERM_CHAR) begin
        // A separator closes the slot opened by the previous one
        if (sep_cnt != 0) begin
          v = slot_value();
          if (sep_cnt == state_sel) pend_state = v;
          if (sep_cnt == rate_sel) pend_rate = v;
        end
        if (sep_cnt != SEP_MAX) sep_cnt++;
        scan_phase = PH_SKIP;
        neg        = 1'b0;
        acc        = '0;
        return;
      end
      if (sep_cnt == 0) return;
      if (scan_phase == PH_SKIP) begin
        if (c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR)) return;
        if (c == MINUS_CHAR || c == PLUS_CHAR) begin
          neg        = (c == MINUS_CHAR);
          scan_phase = PH_DIGITS;
          return;
        end
        scan_phase = PH_DIGITS;
      end
      if (scan_phase == PH_DIGITS) begin
        if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
          a = int'(acc) * 10 + int'(c - ZERO_CHAR);
          if (a > MAG_CAP) a = MAG_CAP;
          acc = a[16:0];
        end else begin
          scan_phase = PH_DONE;
        end
      end
    endfunction

    function void take_byte(bit [7:0] c);
      frame_report_t r;
      if (c != TERM_CHAR) begin
        // Drop bytes past the end of the frame buffer
        if (pos >= FRAME_LEN) begin
          ovf = 1'b1;
          return;
        end
        if (pos == CMD_POS) frame_cmd = c;
        if (pos >= WIN_START && pos <= WIN_END) scan(c);
        pos++;
        return;
      end
      if (pos == CMD_POS) frame_cmd = TERM_CHAR;
      if (pos >= WIN_START && pos <= WIN_END) scan(TERM_CHAR);
      r.command_matched = (frame_cmd == cmd_code);
      if (r.command_matched) begin
        held_state = pend_state;
        held_rate  = pend_rate;
      end
      r.state_value    = held_state;
      r.rate_value     = held_rate;
      r.frame_overflow = ovf;
      awaited.push_back(r);
      clear_frame();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [39:0] data);
      frame_report_t got;
      frame_report_t want;
      got = data[33:0];
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %h with no frame pending", data));
        return;
      end
      want = awaited.pop_front();
      results_checked++;
      if (want.command_matched) matches_seen++;
      if (want.frame_overflow) overflows_seen++;
      if (got.command_matched !== want.command_matched)
        report_mismatch($sformatf("command_matched %b, want %b",
                                  got.command_matched, want.command_matched));
      if (got.state_value !== want.state_value)
        report_mismatch($sformatf("state_value %0d, want %0d",
                                  $signed(got.state_value), $signed(want.state_value)));
      if (got.rate_value !== want.rate_value)
        report_mismatch($sformatf("rate_value %0d, want %0d",
                                  $signed(got.rate_value), $signed(want.rate_value)));
      if (got.frame_overflow !== want.frame_overflow)
        report_mismatch($sformatf("frame_overflow %b, want %b",
                                  got.frame_overflow, want.frame_overflow));
      if (data[39:34] !== 6'd0)
        report_mismatch($sformatf("pad bits %b, want zero", data[39:34]));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_COMMAND_CODE;
  logic [7:0]  cfg_wdata_i   = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] command_matched, [16:1] state_value, [32:17] rate_value, [33] frame_overflow
  logic [39:0] m_axis_tdata;

  frame_parser_shadow sb;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_tick      = 0;
  int unsigned rx_mode      = 0;
  bit          tx_gaps      = 1'b0;
  bit          hold_req     = 1'b0;

  command_frame_field_parser_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: long hold-off on request, otherwise ready on the current pattern
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      rx_tick++;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((rx_tick % 7) >= 3);
      endcase
    end
  end

  // Check results and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("command_frame_field_parser_core regression: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(bit [7:0] b);
    if (tx_gaps && burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b);
    bytes_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(TERM_CHAR);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    bit [7:0]    fr[$];
    int unsigned kind;
    int unsigned w;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // Well-formed: header, command, then slots of whitespace, sign and digits
      fr.push_back(8'($urandom_range(1, 255)));
      fr.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 4) != 0 && sb.cmd_code != TERM_CHAR)
        fr.push_back(sb.cmd_code);
      else
        fr.push_back(8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 5)) begin
        fr.push_back(SEP_CHAR);
        repeat ($urandom_range(0, 2)) begin
          w = $urandom_range(8, 13);
          fr.push_back(w == 8 ? SPACE_CHAR : 8'(w));
        end
        case ($urandom_range(0, 3))
          0: fr.push_back(MINUS_CHAR);
          1: fr.push_back(PLUS_CHAR);
          default: ;
        endcase
        repeat ($urandom_range(0, 6)) fr.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) fr.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 1) != 0) fr.push_back(SEP_CHAR);
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 20))
        fr.push_back($urandom_range(0, 3) == 0 ? SEP_CHAR : 8'($urandom_range(1, 255)));
    end else if (kind < 95) begin
      // Overlong frame
      repeat ($urandom_range(17, 30))
        fr.push_back($urandom_range(0, 3) == 0 ? SEP_CHAR : 8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) fr.push_back(8'($urandom_range(1, 255)));
    end
    foreach (fr[i]) send_byte(fr[i]);
    send_byte(TERM_CHAR);
    frames_sent++;
  endtask

  // Hold the input until every pending report has come back, then let the core settle
  task automatic wait_idle(int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_parser(bit [7:0] cmd, bit [3:0] ss, bit [3:0] rs);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_COMMAND_CODE;
    cfg_wdata_i <= cmd;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_STATE_SLOT;
    cfg_wdata_i <= {4'd0, ss};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RATE_SLOT;
    cfg_wdata_i <= {4'd0, rs};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_register(CFG_COMMAND_CODE, cmd);
    sb.set_register(CFG_STATE_SLOT, {4'd0, ss});
    sb.set_register(CFG_RATE_SLOT, {4'd0, rs});
  endtask

  initial begin
    bit [7:0]    cmd;
    bit [3:0]    ss;
    bit [3:0]    rs;
    int unsigned phase_end;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames on reset register values: empty frame, terminator on the
    // command byte, then saturation, a closed slot, dropped bytes and a late terminator
    send_text("");
    send_text("ab");
    send_text("..l;-99999;+12;xyz");
    wait_idle(4);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cmd = CMD_RESET;
          ss  = STATE_SLOT_RESET;
          rs  = RATE_SLOT_RESET;
        end
        1: begin
          cmd = 8'hFF;
          ss  = 4'd0;
          rs  = 4'd12;
        end
        2: begin
          cmd = 8'h00;
          ss  = 4'd12;
          rs  = 4'd0;
        end
        default: begin
          cmd = 8'($urandom_range(0, 255));
          ss  = 4'($urandom_range(0, 12));
          rs  = 4'($urandom_range(0, 12));
        end
      endcase
      program_parser(cmd, ss, rs);
      rx_mode   = ph % 3;
      tx_gaps   = (ph % 2 == 1);
      hold_req  = (ph == 1 || ph == 4);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_frame();
      wait_idle(10);
    end

    $display("checked %0d frame reports from %0d bytes in %0d frames (%0d matched, %0d overflow)",
             sb.results_checked, bytes_sent, frames_sent, sb.matches_seen, sb.overflows_seen);
    $display("covered reset, extreme and random register settings with hold-offs and gaps");
    if (sb.mismatches == 0)
      $display("command_frame_field_parser_core regression: pass");
    else
      $display("command_frame_field_parser_core regression: fail");
    $finish;
  end

endmodule

/* command_frame_field_parser_core.f */
+incdir+design
design/cffp_pkg.sv
design/command_frame_field_parser_core.sv
bench/tb_command_frame_field_parser_core.sv
